// ===== rtl/prt_pkg.sv =====
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types and constants of the primality tester: sequencer states and
// the fixed Miller-Rabin base table.
// ----------------------------------------------------------------------------
package prt_pkg;

   // number of fixed bases and width of the widest one
   localparam int NUM_BASES = 7;
   localparam int BASE_W    = 31;
   localparam int IDX_W     = $clog2(NUM_BASES);

   // deterministic base set for candidates below 2^64
   localparam logic [BASE_W-1:0] MR_BASES [NUM_BASES] = '{
      31'd2, 31'd325, 31'd9375, 31'd28178, 31'd450775, 31'd9780504,
      31'd1795265022
   };

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_STRIP,
      ST_BASE_START,
      ST_BASE_WAIT,
      ST_POW_CHECK,
      ST_POW_MUL_WAIT,
      ST_POW_SQR_WAIT,
      ST_EVAL,
      ST_SQ_CHECK,
      ST_SQ_WAIT,
      ST_NEXT_BASE,
      ST_FINISH
   } prt_state_type;

endpackage

// ===== rtl/primality_tester_core.sv =====
// ----------------------------------------------------------------------------
// primality_tester_core
// Deterministic Miller-Rabin test of one candidate per word, sequenced over a
// shared serial modular multiplier.
// ----------------------------------------------------------------------------
// Run time: values below 3 and even values settle without the multiplier;
//   otherwise it grows with the number of modular multiplications and the bits
//   of their y operands, consumed by the one-bit-per-cycle modular multiplier.
// Throughput: one candidate at a time; the next word is taken once the
//   verdict sits in the output register.
// Reset: synchronous, clears the sequencer and the result valid flag.
// ----------------------------------------------------------------------------
module primality_tester_core #(
   parameter int WIDTH = 63
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [((WIDTH+7)/8)*8-1:0]    req_tdata,   // [WIDTH-1:0] candidate
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata    // [0] is_prime
);

   localparam int YW = (WIDTH > prt_pkg::BASE_W) ? WIDTH : prt_pkg::BASE_W;
   localparam int SW = $clog2(WIDTH + 1);

   prt_pkg::prt_state_type state_ff, state_in;

   logic [WIDTH-1:0]          n_ff, n_in;
   logic [WIDTH-1:0]          nm1_ff, nm1_in;
   logic [WIDTH-1:0]          d_ff, d_in;
   logic [WIDTH-1:0]          ex_ff, ex_in;
   logic [WIDTH-1:0]          acc_ff, acc_in;
   logic [WIDTH-1:0]          base_ff, base_in;
   logic [SW-1:0]             s_ff, s_in;
   logic [SW-1:0]             k_ff, k_in;
   logic [prt_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                      verdict_ff, verdict_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_prime_ff, rsp_prime_in;

   logic             mm_start;
   logic [WIDTH-1:0] mm_x;
   logic [YW-1:0]    mm_y;
   logic             mm_done;
   logic [WIDTH-1:0] mm_product;
   logic             out_free;

   prt_mulmod #(
      .WIDTH (WIDTH),
      .YW    (YW)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .op_x    (mm_x),
      .op_y    (mm_y),
      .modulus (n_ff),
      .done    (mm_done),
      .product (mm_product)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == prt_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_prime_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prt_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = prt_pkg::ST_CHECK;
         end
         prt_pkg::ST_CHECK: begin
            if (n_ff < WIDTH'(3) || !n_ff[0]) state_in = prt_pkg::ST_FINISH;
            else state_in = prt_pkg::ST_STRIP;
         end
         prt_pkg::ST_STRIP: begin
            if (d_ff[0]) state_in = prt_pkg::ST_BASE_START;
         end
         prt_pkg::ST_BASE_START: state_in = prt_pkg::ST_BASE_WAIT;
         prt_pkg::ST_BASE_WAIT: begin
            if (mm_done) begin
               if (mm_product == '0) state_in = prt_pkg::ST_NEXT_BASE;
               else state_in = prt_pkg::ST_POW_CHECK;
            end
         end
         prt_pkg::ST_POW_CHECK: begin
            if (ex_ff == '0) state_in = prt_pkg::ST_EVAL;
            else if (ex_ff[0]) state_in = prt_pkg::ST_POW_MUL_WAIT;
            else state_in = prt_pkg::ST_POW_SQR_WAIT;
         end
         prt_pkg::ST_POW_MUL_WAIT: begin
            if (mm_done) state_in = prt_pkg::ST_POW_SQR_WAIT;
         end
         prt_pkg::ST_POW_SQR_WAIT: begin
            if (mm_done) state_in = prt_pkg::ST_POW_CHECK;
         end
         prt_pkg::ST_EVAL: begin
            if (acc_ff == WIDTH'(1) || acc_ff == nm1_ff) state_in = prt_pkg::ST_NEXT_BASE;
            else state_in = prt_pkg::ST_SQ_CHECK;
         end
         prt_pkg::ST_SQ_CHECK: begin
            if (k_ff < s_ff) state_in = prt_pkg::ST_SQ_WAIT;
            else state_in = prt_pkg::ST_FINISH;
         end
         prt_pkg::ST_SQ_WAIT: begin
            if (mm_done) begin
               if (mm_product == nm1_ff) state_in = prt_pkg::ST_NEXT_BASE;
               else state_in = prt_pkg::ST_SQ_CHECK;
            end
         end
         prt_pkg::ST_NEXT_BASE: begin
            if (idx_ff == prt_pkg::IDX_W'(prt_pkg::NUM_BASES - 1)) begin
               state_in = prt_pkg::ST_FINISH;
            end else begin
               state_in = prt_pkg::ST_BASE_START;
            end
         end
         prt_pkg::ST_FINISH: begin
            if (out_free) state_in = prt_pkg::ST_IDLE;
         end
         default: state_in = prt_pkg::ST_IDLE;
      endcase
   end

   // datapath loads and multiplier requests
   always_comb begin
      n_in         = n_ff;
      nm1_in       = nm1_ff;
      d_in         = d_ff;
      ex_in        = ex_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      s_in         = s_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_prime_in = rsp_prime_ff;
      mm_start     = 1'b0;
      mm_x         = acc_ff;
      mm_y         = YW'(acc_ff);
      case (state_ff)
         prt_pkg::ST_IDLE: begin
            n_in = req_tdata[WIDTH-1:0];
         end
         // small and even values settle at once
         prt_pkg::ST_CHECK: begin
            verdict_in = (n_ff == WIDTH'(2));
            nm1_in     = n_ff - WIDTH'(1);
            d_in       = n_ff - WIDTH'(1);
            s_in       = '0;
            idx_in     = '0;
         end
         // strip factors of two from n-1
         prt_pkg::ST_STRIP: begin
            if (!d_ff[0]) begin
               d_in = d_ff >> 1;
               s_in = s_ff + SW'(1);
            end
         end
         // reduce the base: 1 * base mod n
         prt_pkg::ST_BASE_START: begin
            mm_start = 1'b1;
            mm_x     = WIDTH'(1);
            mm_y     = YW'(prt_pkg::MR_BASES[idx_ff]);
         end
         prt_pkg::ST_BASE_WAIT: begin
            if (mm_done) begin
               base_in = mm_product;
               acc_in  = WIDTH'(1);
               ex_in   = d_ff;
            end
         end
         // square-and-multiply over the exponent, low bit first
         prt_pkg::ST_POW_CHECK: begin
            if (ex_ff != '0) begin
               mm_start = 1'b1;
               if (ex_ff[0]) begin
                  mm_x = acc_ff;
                  mm_y = YW'(base_ff);
               end else begin
                  mm_x = base_ff;
                  mm_y = YW'(base_ff);
               end
            end
         end
         prt_pkg::ST_POW_MUL_WAIT: begin
            if (mm_done) begin
               acc_in   = mm_product;
               mm_start = 1'b1;
               mm_x     = base_ff;
               mm_y     = YW'(base_ff);
            end
         end
         prt_pkg::ST_POW_SQR_WAIT: begin
            if (mm_done) begin
               base_in = mm_product;
               ex_in   = ex_ff >> 1;
            end
         end
         prt_pkg::ST_EVAL: begin
            k_in = SW'(1);
         end
         // repeated squaring looking for n-1
         prt_pkg::ST_SQ_CHECK: begin
            if (k_ff < s_ff) begin
               mm_start = 1'b1;
               mm_x     = acc_ff;
               mm_y     = YW'(acc_ff);
            end else begin
               verdict_in = 1'b0;
            end
         end
         prt_pkg::ST_SQ_WAIT: begin
            if (mm_done) begin
               acc_in = mm_product;
               k_in   = k_ff + SW'(1);
            end
         end
         prt_pkg::ST_NEXT_BASE: begin
            if (idx_ff == prt_pkg::IDX_W'(prt_pkg::NUM_BASES - 1)) begin
               verdict_in = 1'b1;
            end else begin
               idx_in = idx_ff + prt_pkg::IDX_W'(1);
            end
         end
         // hand the verdict to the output register once it is free
         prt_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = verdict_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      nm1_ff       <= nm1_in;
      d_ff         <= d_in;
      ex_ff        <= ex_in;
      acc_ff       <= acc_in;
      base_ff      <= base_in;
      s_ff         <= s_in;
      k_ff         <= k_in;
      idx_ff       <= idx_in;
      verdict_ff   <= verdict_in;
      rsp_prime_ff <= rsp_prime_in;
   end

endmodule

// ===== rtl/prt_mulmod.sv =====
// ----------------------------------------------------------------------------
// prt_mulmod
// Shift-and-add modular multiplier: one bit of the y operand per cycle, with
// the accumulate and the doubling both taken modulo m on widened sums.
// ----------------------------------------------------------------------------
module prt_mulmod #(
   parameter int WIDTH = 63,
   parameter int YW    = 63
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] op_x,
   input  logic [YW-1:0]    op_y,
   input  logic [WIDTH-1:0] modulus,
   output logic             done,
   output logic [WIDTH-1:0] product
);

   logic             busy_ff, busy_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [YW-1:0]    y_ff, y_in;

   // (a + b) mod m for a, b < m, one bit wider so the sum cannot wrap
   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                                input logic [WIDTH-1:0] b,
                                                input logic [WIDTH-1:0] m);
      logic [WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[WIDTH-1:0];
   endfunction

   // finished once every bit of y has been consumed
   assign done    = busy_ff && (y_ff == '0);
   assign product = acc_ff;

   // one add-double step per cycle
   always_comb begin
      busy_in = busy_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      if (start) begin
         busy_in = 1'b1;
         acc_in  = '0;
         x_in    = op_x;
         y_in    = op_y;
      end else if (busy_ff) begin
         if (y_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (y_ff[0]) begin
               acc_in = add_mod(acc_ff, x_ff, modulus);
            end
            x_in = add_mod(x_ff, x_ff, modulus);
            y_in = y_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

endmodule
